>>> rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they expand to nothing in synthesis builds.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked only while reset is low
`define AFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every edge, reset included
`define AFD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFD_ASSERT(lbl, clk, rst, prop, msg)
`define AFD_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/afd_pkg.sv
// -----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the accelerometer fall detector.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afd_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int LEVEL_W    = 15;
   localparam int TOL_W      = 12;
   localparam int COS_W      = 16;
   localparam int WIN_W      = 16;
   localparam int BAND_W     = 13;            // 1 g +/- tolerance fits 13 bits
   localparam int LEVEL_SQ_W = 2 * LEVEL_W;
   localparam int BAND_SQ_W  = 2 * BAND_W;
   localparam int COS_SQ_W   = 2 * COS_W;     // also the tilt compare shift

   localparam logic [BAND_W-1:0] ONE_G = 13'd4096;
   // smallest m2 with 100*m2 >= 1 g squared (magnitude at least 0.1 g)
   localparam int TILT_MIN_M2 = (4096 * 4096 + 99) / 100;

   localparam logic [LEVEL_W-1:0] RST_FREEFALL_LEVEL  = 15'd3277;
   localparam logic [LEVEL_W-1:0] RST_IMPACT_LEVEL    = 15'd6144;
   localparam logic [TOL_W-1:0]   RST_STILL_TOLERANCE = 12'd1229;
   localparam logic [COS_W-1:0]   RST_TILT_COSINE     = 16'd56756;
   localparam logic [WIN_W-1:0]   RST_FREEFALL_WINDOW = 16'd300;
   localparam logic [WIN_W-1:0]   RST_STILL_DURATION  = 16'd2000;
   localparam logic [LEVEL_W-1:0] RST_RECOVER_LOW     = 15'd3277;
   localparam logic [LEVEL_W-1:0] RST_RECOVER_HIGH    = 15'd4915;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FREEFALL_LEVEL  = 3'd0,
      CSR_IMPACT_LEVEL    = 3'd1,
      CSR_STILL_TOLERANCE = 3'd2,
      CSR_TILT_COSINE     = 3'd3,
      CSR_FREEFALL_WINDOW = 3'd4,
      CSR_STILL_DURATION  = 3'd5,
      CSR_RECOVER_LOW     = 3'd6,
      CSR_RECOVER_HIGH    = 3'd7
   } csr_addr_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_FREEFALL = 2'd1,
      PH_IMPACT   = 2'd2,
      PH_FALL     = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CS_WAIT,
      CS_SQUARE,
      CS_SUM,
      CS_TILT_LO,
      CS_TILT_HI,
      CS_DECIDE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic tilt_lo;
      logic tilt_hi;
      logic decide;
   } dp_cmd_type;

   typedef struct packed {
      logic      skip;     // clear request or invalid sample: no arithmetic
      phase_type phase;
   } dp_status_type;

   typedef struct packed {
      logic [LEVEL_SQ_W-1:0] freefall_sq;
      logic [LEVEL_SQ_W-1:0] impact_sq;
      logic [LEVEL_SQ_W-1:0] recover_low_sq;
      logic [LEVEL_SQ_W-1:0] recover_high_sq;
      logic [BAND_SQ_W-1:0]  still_low_sq;
      logic [BAND_SQ_W-1:0]  still_high_sq;
      logic [COS_SQ_W-1:0]   tilt_cos_sq;
      logic [WIN_W-1:0]      freefall_window;
      logic [WIN_W-1:0]      still_duration;
   } cfg_type;

endpackage

>>> rtl/afd_csr.sv
// -----------------------------------------------------------------------------
// afd_csr
// Configuration registers and their registered squares.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afd_csr import afd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   logic [LEVEL_W-1:0] freefall_level_ff,  freefall_level_in;
   logic [LEVEL_W-1:0] impact_level_ff,    impact_level_in;
   logic [TOL_W-1:0]   still_tol_ff,       still_tol_in;
   logic [COS_W-1:0]   tilt_cos_ff,        tilt_cos_in;
   logic [WIN_W-1:0]   freefall_window_ff, freefall_window_in;
   logic [WIN_W-1:0]   still_duration_ff,  still_duration_in;
   logic [LEVEL_W-1:0] recover_low_ff,     recover_low_in;
   logic [LEVEL_W-1:0] recover_high_ff,    recover_high_in;

   logic [BAND_W-1:0]     still_low, still_high;
   logic [LEVEL_SQ_W-1:0] freefall_sq_ff, impact_sq_ff, rec_low_sq_ff, rec_high_sq_ff;
   logic [BAND_SQ_W-1:0]  still_low_sq_ff, still_high_sq_ff;
   logic [COS_SQ_W-1:0]   tilt_cos_sq_ff;

   always_comb begin
      freefall_level_in  = freefall_level_ff;
      impact_level_in    = impact_level_ff;
      still_tol_in       = still_tol_ff;
      tilt_cos_in        = tilt_cos_ff;
      freefall_window_in = freefall_window_ff;
      still_duration_in  = still_duration_ff;
      recover_low_in     = recover_low_ff;
      recover_high_in    = recover_high_ff;
      if (csr_wr_en) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_FREEFALL_LEVEL:  freefall_level_in  = csr_wr_data[LEVEL_W-1:0];
            CSR_IMPACT_LEVEL:    impact_level_in    = csr_wr_data[LEVEL_W-1:0];
            CSR_STILL_TOLERANCE: still_tol_in       = csr_wr_data[TOL_W-1:0];
            CSR_TILT_COSINE:     tilt_cos_in        = csr_wr_data[COS_W-1:0];
            CSR_FREEFALL_WINDOW: freefall_window_in = csr_wr_data[WIN_W-1:0];
            CSR_STILL_DURATION:  still_duration_in  = csr_wr_data[WIN_W-1:0];
            CSR_RECOVER_LOW:     recover_low_in     = csr_wr_data[LEVEL_W-1:0];
            CSR_RECOVER_HIGH:    recover_high_in    = csr_wr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freefall_level_ff  <= RST_FREEFALL_LEVEL;
         impact_level_ff    <= RST_IMPACT_LEVEL;
         still_tol_ff       <= RST_STILL_TOLERANCE;
         tilt_cos_ff        <= RST_TILT_COSINE;
         freefall_window_ff <= RST_FREEFALL_WINDOW;
         still_duration_ff  <= RST_STILL_DURATION;
         recover_low_ff     <= RST_RECOVER_LOW;
         recover_high_ff    <= RST_RECOVER_HIGH;
      end else begin
         freefall_level_ff  <= freefall_level_in;
         impact_level_ff    <= impact_level_in;
         still_tol_ff       <= still_tol_in;
         tilt_cos_ff        <= tilt_cos_in;
         freefall_window_ff <= freefall_window_in;
         still_duration_ff  <= still_duration_in;
         recover_low_ff     <= recover_low_in;
         recover_high_ff    <= recover_high_in;
      end
   end

   assign still_low  = ONE_G - BAND_W'(still_tol_ff);
   assign still_high = ONE_G + BAND_W'(still_tol_ff);

   // squares are registered, updating in the cycle after their registers change
   always_ff @(posedge clock) begin
      freefall_sq_ff   <= LEVEL_SQ_W'(freefall_level_ff) * LEVEL_SQ_W'(freefall_level_ff);
      impact_sq_ff     <= LEVEL_SQ_W'(impact_level_ff) * LEVEL_SQ_W'(impact_level_ff);
      rec_low_sq_ff    <= LEVEL_SQ_W'(recover_low_ff) * LEVEL_SQ_W'(recover_low_ff);
      rec_high_sq_ff   <= LEVEL_SQ_W'(recover_high_ff) * LEVEL_SQ_W'(recover_high_ff);
      still_low_sq_ff  <= BAND_SQ_W'(still_low) * BAND_SQ_W'(still_low);
      still_high_sq_ff <= BAND_SQ_W'(still_high) * BAND_SQ_W'(still_high);
      tilt_cos_sq_ff   <= COS_SQ_W'(tilt_cos_ff) * COS_SQ_W'(tilt_cos_ff);
   end

   always_comb begin
      cfg.freefall_sq     = freefall_sq_ff;
      cfg.impact_sq       = impact_sq_ff;
      cfg.recover_low_sq  = rec_low_sq_ff;
      cfg.recover_high_sq = rec_high_sq_ff;
      cfg.still_low_sq    = still_low_sq_ff;
      cfg.still_high_sq   = still_high_sq_ff;
      cfg.tilt_cos_sq     = tilt_cos_sq_ff;
      cfg.freefall_window = freefall_window_ff;
      cfg.still_duration  = still_duration_ff;
   end

endmodule

>>> rtl/afd_ctrl.sv
// -----------------------------------------------------------------------------
// afd_ctrl
// Sequencer: steps the datapath through one item and owns the result valid.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afd_ctrl import afd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // result slot is free if empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_WAIT:    if (req_valid) state_in = CS_SQUARE;
         CS_SQUARE:  state_in = status.skip ? CS_DECIDE : CS_SUM;
         CS_SUM:     state_in = CS_TILT_LO;
         CS_TILT_LO: state_in = CS_TILT_HI;
         CS_TILT_HI: state_in = CS_DECIDE;
         CS_DECIDE:  if (out_free) state_in = CS_WAIT;
         default:    state_in = CS_WAIT;
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         CS_WAIT: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         CS_SQUARE:  cmd.square  = 1'b1;
         CS_SUM:     cmd.sum     = 1'b1;
         CS_TILT_LO: cmd.tilt_lo = 1'b1;
         CS_TILT_HI: cmd.tilt_hi = 1'b1;
         CS_DECIDE:  cmd.decide  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/afd_dpath.sv
// -----------------------------------------------------------------------------
// afd_dpath
// Datapath: squared magnitude, split tilt product, phase tracking, result reg.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afd_dpath import afd_pkg::*; #(
   parameter int ACCEL_BITS = 16,
   parameter int TICK_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   input  cfg_type                      cfg,
   input  logic                         req_type,
   input  logic                         req_sample_valid,
   input  logic signed [ACCEL_BITS-1:0] req_accel_x,
   input  logic signed [ACCEL_BITS-1:0] req_accel_y,
   input  logic signed [ACCEL_BITS-1:0] req_accel_z,
   input  logic        [TICK_BITS-1:0]  req_tick_now,
   output dp_status_type                status,
   output logic                         rsp_fall_detected
);

   localparam int SQ_W   = 2 * ACCEL_BITS;          // holds x^2+y^2+z^2
   localparam int HALF_W = ACCEL_BITS;
   localparam int PP_W   = COS_SQ_W + HALF_W;
   localparam int PROD_W = SQ_W + COS_SQ_W;
   localparam int CMP_W  = (SQ_W > LEVEL_SQ_W) ? SQ_W : LEVEL_SQ_W;

   logic                         clr_ff, clr_in;
   logic                         valid_ff, valid_in;
   logic signed [ACCEL_BITS-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic        [TICK_BITS-1:0]  tick_ff, tick_in;
   logic        [SQ_W-1:0]       xx_ff, xx_in, yy_ff, yy_in, zz_ff, zz_in;
   logic        [SQ_W-1:0]       m2_ff, m2_in;
   logic        [PP_W-1:0]       plo_ff, plo_in, phi_ff, phi_in;
   phase_type                    phase_ff, phase_in;
   logic        [TICK_BITS-1:0]  ff_time_ff, ff_time_in, imp_time_ff, imp_time_in;
   logic                         alarm_ff, alarm_in;
   logic                         fall_ff, fall_in;

   logic signed [SQ_W-1:0]   xs, ys, zs;
   logic        [HALF_W-1:0] m2_half;
   logic        [PP_W-1:0]   pp;
   logic        [PROD_W-1:0] tilt_rhs, tilt_lhs;
   logic        [CMP_W-1:0]  m2c;
   logic        [TICK_BITS-1:0] ff_dt, imp_dt;
   logic                     ff_late, imp_late, still, tilted;

   // input capture
   assign clr_in   = cmd.load ? req_type         : clr_ff;
   assign valid_in = cmd.load ? req_sample_valid : valid_ff;
   assign x_in     = cmd.load ? req_accel_x      : x_ff;
   assign y_in     = cmd.load ? req_accel_y      : y_ff;
   assign z_in     = cmd.load ? req_accel_z      : z_ff;
   assign tick_in  = cmd.load ? req_tick_now     : tick_ff;

   // squares of the three axes
   assign xs    = SQ_W'(x_ff);
   assign ys    = SQ_W'(y_ff);
   assign zs    = SQ_W'(z_ff);
   assign xx_in = cmd.square ? $unsigned(xs * xs) : xx_ff;
   assign yy_in = cmd.square ? $unsigned(ys * ys) : yy_ff;
   assign zz_in = cmd.square ? $unsigned(zs * zs) : zz_ff;
   assign m2_in = cmd.sum ? (xx_ff + yy_ff + zz_ff) : m2_ff;

   // cos^2 * m2 in two partial products over one shared multiplier
   assign m2_half = cmd.tilt_hi ? m2_ff[SQ_W-1:HALF_W] : m2_ff[HALF_W-1:0];
   assign pp      = PP_W'(cfg.tilt_cos_sq) * PP_W'(m2_half);
   assign plo_in  = cmd.tilt_lo ? pp : plo_ff;
   assign phi_in  = cmd.tilt_hi ? pp : phi_ff;

   assign tilt_rhs = PROD_W'(plo_ff) + (PROD_W'(phi_ff) << HALF_W);
   assign tilt_lhs = {zz_ff, {COS_SQ_W{1'b0}}};

   assign m2c      = CMP_W'(m2_ff);
   assign ff_dt    = tick_ff - ff_time_ff;
   assign imp_dt   = tick_ff - imp_time_ff;
   assign ff_late  = ff_dt  > TICK_BITS'(cfg.freefall_window);
   assign imp_late = imp_dt > TICK_BITS'(cfg.still_duration);
   assign still    = (m2c > CMP_W'(cfg.still_low_sq)) && (m2c < CMP_W'(cfg.still_high_sq));
   // negative z always counts as tilted once the magnitude test passes
   assign tilted   = (m2c >= CMP_W'(TILT_MIN_M2)) &&
                     (z_ff[ACCEL_BITS-1] || (tilt_lhs < tilt_rhs));

   always_comb begin
      phase_in    = phase_ff;
      ff_time_in  = ff_time_ff;
      imp_time_in = imp_time_ff;
      alarm_in    = alarm_ff;
      fall_in     = fall_ff;
      if (cmd.decide) begin
         fall_in = 1'b0;
         if (clr_ff) begin
            phase_in = PH_IDLE;
            alarm_in = 1'b0;
         end else if (valid_ff) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (m2c < CMP_W'(cfg.freefall_sq)) begin
                     phase_in   = PH_FREEFALL;
                     ff_time_in = tick_ff;
                  end
               end
               PH_FREEFALL: begin
                  if (ff_late) begin
                     phase_in = PH_IDLE;
                  end else if (m2c > CMP_W'(cfg.impact_sq)) begin
                     phase_in    = PH_IMPACT;
                     imp_time_in = tick_ff;
                  end else if ((m2c > CMP_W'(cfg.recover_low_sq)) &&
                               (m2c < CMP_W'(cfg.recover_high_sq))) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_IMPACT: begin
                  if (imp_late) begin
                     if (still && tilted) begin
                        phase_in = PH_FALL;
                        alarm_in = 1'b0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_FALL: begin
                  if (!alarm_ff) begin
                     alarm_in = 1'b1;
                     fall_in  = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         ff_time_ff  <= '0;
         imp_time_ff <= '0;
         alarm_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         ff_time_ff  <= ff_time_in;
         imp_time_ff <= imp_time_in;
         alarm_ff    <= alarm_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff   <= clr_in;
      valid_ff <= valid_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      tick_ff  <= tick_in;
      xx_ff    <= xx_in;
      yy_ff    <= yy_in;
      zz_ff    <= zz_in;
      m2_ff    <= m2_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      fall_ff  <= fall_in;
   end

   assign status.skip  = clr_ff || !valid_ff;
   assign status.phase = phase_ff;

   assign rsp_fall_detected = fall_ff;

endmodule

>>> rtl/accel_fall_detector.sv
// An accepted sample steps through load, square, sum, two tilt partial
// products and decide; a clear request or an invalid sample goes from square
// straight to decide. A new request is taken only once the last one is done;
// a stalled result holds the decide step until the result register frees.
// Reset (synchronous): phase idle, stored times zero, alarm cleared, registers
// back to their defaults, no result pending.
// -----------------------------------------------------------------------------
// accel_fall_detector
// Threshold fall detector over three-axis accelerometer samples.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module accel_fall_detector import afd_pkg::*; #(
   parameter int ACCEL_BITS = 16,
   parameter int TICK_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic                         req_sample_valid,
   input  logic signed [ACCEL_BITS-1:0] req_accel_x,
   input  logic signed [ACCEL_BITS-1:0] req_accel_y,
   input  logic signed [ACCEL_BITS-1:0] req_accel_z,
   input  logic        [TICK_BITS-1:0]  req_tick_now,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_fall_detected,
   input  logic                         csr_wr_en,
   input  logic        [CSR_ADDR_W-1:0] csr_addr,
   input  logic        [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type dp_status;

   afd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   afd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (cmd)
   );

   afd_dpath #(
      .ACCEL_BITS (ACCEL_BITS),
      .TICK_BITS  (TICK_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_type          (req_type),
      .req_sample_valid  (req_sample_valid),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_tick_now      (req_tick_now),
      .status            (dp_status),
      .rsp_fall_detected (rsp_fall_detected)
   );

   `AFD_ASSERT(a_alarm_in_fall, clock, reset, (rsp_valid && rsp_fall_detected) |-> (dp_status.phase == PH_FALL), "alarm pending outside fall phase")
   `AFD_ASSERT(a_no_overwrite, clock, reset, cmd.decide |-> (!rsp_valid || !rsp_stall), "result overwritten while stalled")
   `AFD_ASSERT(a_one_step, clock, reset, $onehot0(cmd), "more than one datapath step at once")
   `AFD_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "result pending after reset")

endmodule
